// File: src/utf8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and byte constants shared by the UTF-8 validate and newline
// normalise core.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_TAG   = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_TAG  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_TAG  = 8'b1110_0000;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_TAG  = 8'b1111_0000;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] BOM_B0 = 8'hEF;
  localparam logic [7:0] BOM_B1 = 8'hBB;
  localparam logic [7:0] BOM_B2 = 8'hBF;

  typedef struct packed {
    logic [1:0]  need_count;
    logic        cr_pending;
    logic        at_frame_start;
    logic [15:0] mark_hold;
    logic [1:0]  mark_hold_count;
    logic        error_seen;
    logic        mark_stripped;
  } frame_state_t;

  localparam frame_state_t FRAME_STATE_RESET = '{
    need_count:      2'd0,
    cr_pending:      1'b0,
    at_frame_start:  1'b1,
    mark_hold:       16'h0000,
    mark_hold_count: 2'd0,
    error_seen:      1'b0,
    mark_stripped:   1'b0
  };

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic       byte_valid;
    logic       frame_done;
    logic       frame_ok;
    logic       bom_removed;
  } step_run_t;

endpackage

// File: src/utf8v_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_step
// Per-byte decode: sequence structure check, mark hold and strip, CR / CR LF
// to LF, frame end status. Gives the next frame state and the run of up to
// three results caused by one item.
// ----------------------------------------------------------------------------
module utf8v_step
  import utf8v_pkg::*;
(
  input  frame_state_t state_cur,
  input  logic [7:0]   in_byte,
  input  logic         in_frame_end,
  output frame_state_t state_nxt,
  output step_run_t    run
);

  logic       fresh_error;
  logic [1:0] n;
  logic       ok;

  always_comb begin
    state_nxt                = state_cur;
    state_nxt.at_frame_start = 1'b0;
    run                      = '0;
    run.byte_valid           = 1'b1;
    n                        = 2'd0;
    fresh_error              = 1'b0;
    ok                       = 1'b0;

    if (!state_cur.error_seen) begin
      if (state_cur.need_count == 2'd0) begin
        if (state_cur.cr_pending && in_byte == CHAR_LF) begin
          state_nxt.cr_pending = 1'b0;
        end else begin
          state_nxt.cr_pending = 1'b0;
          if (!in_byte[7]) begin
            n = 2'd1;
            if (in_byte == CHAR_CR) begin
              run.data0            = CHAR_LF;
              state_nxt.cr_pending = 1'b1;
            end else begin
              run.data0 = in_byte;
            end
          end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
            state_nxt.need_count = 2'd1;
            run.data0            = in_byte;
            n                    = 2'd1;
          end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
            state_nxt.need_count = 2'd2;
            if (state_cur.at_frame_start && in_byte == BOM_B0) begin
              state_nxt.mark_hold       = {8'h00, in_byte};
              state_nxt.mark_hold_count = 2'd1;
            end else begin
              run.data0 = in_byte;
              n         = 2'd1;
            end
          end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
            state_nxt.need_count = 2'd3;
            run.data0            = in_byte;
            n                    = 2'd1;
          end else begin
            fresh_error = 1'b1;
          end
        end
      end else if ((in_byte & CONT_MASK) != CONT_TAG) begin
        fresh_error = 1'b1;
      end else begin
        state_nxt.need_count = state_cur.need_count - 2'd1;
        case (state_cur.mark_hold_count)
          2'd1: begin
            if (in_byte == BOM_B1) begin
              state_nxt.mark_hold       = {BOM_B1, state_cur.mark_hold[7:0]};
              state_nxt.mark_hold_count = 2'd2;
            end else begin
              run.data0                 = state_cur.mark_hold[7:0];
              run.data1                 = in_byte;
              n                         = 2'd2;
              state_nxt.mark_hold       = '0;
              state_nxt.mark_hold_count = 2'd0;
            end
          end
          2'd2: begin
            if (in_byte == BOM_B2) begin
              state_nxt.mark_stripped = 1'b1;
            end else begin
              run.data0 = state_cur.mark_hold[7:0];
              run.data1 = state_cur.mark_hold[15:8];
              run.data2 = in_byte;
              n         = 2'd3;
            end
            state_nxt.mark_hold       = '0;
            state_nxt.mark_hold_count = 2'd0;
          end
          default: begin
            run.data0 = in_byte;
            n         = 2'd1;
          end
        endcase
      end
      if (!fresh_error && in_frame_end && state_nxt.need_count != 2'd0) begin
        fresh_error = 1'b1;
      end
      if (fresh_error) begin
        state_nxt.error_seen = 1'b1;
        n                    = 2'd0;
      end
    end

    if (in_frame_end) begin
      ok              = !state_nxt.error_seen;
      run.frame_done  = 1'b1;
      run.frame_ok    = ok;
      run.bom_removed = ok && state_nxt.mark_stripped;
      if (n == 2'd0) begin
        run       = '0;
        run.frame_done  = 1'b1;
        run.frame_ok    = ok;
        run.bom_removed = ok && state_nxt.mark_stripped;
        n         = 2'd1;
      end
      state_nxt = FRAME_STATE_RESET;
    end

    run.count = n;
  end

endmodule

// File: src/utf8_validate_newline_normalize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_newline_normalize_core
// UTF-8 frame checker with leading byte order mark strip and CR / CR LF to LF
// conversion; one text byte per item, frame status on the last result.
// ----------------------------------------------------------------------------
//  channel | ports                                      | dir | handshake
//  in      | in_byte, in_frame_end                      | in  | in_valid / in_ready
//  out     | out_byte, out_byte_valid, out_run_last,    | out | out_valid / out_ready
//          | out_frame_done, out_frame_ok, out_bom_removed
//
//  An item is decoded in the cycle it is accepted and its results are held
//  in a three-entry run register that drains one result per cycle.
//  Items giving one result flow at one per cycle while out_ready is high;
//  an item giving no result is taken without occupying the output.
//  Reset clears the frame state and empties the run register.
//  A stall on out holds the run; in_ready stays high while the run is empty
//  or its last result is being taken.
// ----------------------------------------------------------------------------
module utf8_validate_newline_normalize_core
  import utf8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_frame_done,
  output logic       out_frame_ok,
  output logic       out_bom_removed
);

  frame_state_t state_r, state_nxt;
  step_run_t    run_step;
  step_run_t    run_r, run_nxt;
  logic         in_take;
  logic         out_take;

  utf8v_step u_step (
    .state_cur    (state_r),
    .in_byte      (in_byte),
    .in_frame_end (in_frame_end),
    .state_nxt    (state_nxt),
    .run          (run_step)
  );

  assign out_valid = run_r.count != 2'd0;
  assign out_take  = out_valid && out_ready;
  assign in_ready  = (run_r.count == 2'd0) || (run_r.count == 2'd1 && out_ready);
  assign in_take   = in_valid && in_ready;

  always_comb begin
    run_nxt = run_r;
    if (out_take) begin
      run_nxt.data0 = run_r.data1;
      run_nxt.data1 = run_r.data2;
      run_nxt.count = run_r.count - 2'd1;
    end
    if (in_take) begin
      run_nxt = run_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FRAME_STATE_RESET;
      run_r   <= '0;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
      end
      run_r <= run_nxt;
    end
  end

  assign out_byte        = run_r.data0;
  assign out_byte_valid  = run_r.byte_valid;
  assign out_run_last    = run_r.count == 2'd1;
  assign out_frame_done  = out_run_last && run_r.frame_done;
  assign out_frame_ok    = out_run_last && run_r.frame_ok;
  assign out_bom_removed = out_run_last && run_r.bom_removed;

endmodule

// File: tb/tb_utf8_validate_newline_normalize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_validate_newline_normalize_core
// Self-checking bench for the UTF-8 frame checker. Text frames are fed one
// byte per item in random bursts while the result side stalls on its own
// pattern. A behavioural model of the byte order mark strip, sequence check
// and CR / CR LF folding predicts every result, and each result is compared
// field by field. Directed frames come first, then random frames, most of
// them well formed and some broken.
// ----------------------------------------------------------------------------
module tb_utf8_validate_newline_normalize_core;
  import utf8v_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       run_end;
    logic       done;
    logic       ok;
    logic       mark;
  } text_result_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_LONG_HOLD
  } rx_mode_t;

  localparam int RANDOM_ITEMS = 70;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_frame_done;
  logic       out_frame_ok;
  logic       out_bom_removed;

  // model of the frame state
  logic [1:0]  pend_cont;
  logic        cr_seen;
  logic        frame_first;
  logic [15:0] hold_bytes;
  logic [1:0]  hold_cnt;
  logic        frame_bad;
  logic        mark_dropped;

  text_result_t expected_text[$];
  logic [7:0]   frame_q[$];

  int mismatches = 0;
  int live_items = 0;
  int frames_sent = 0;
  int frames_bad = 0;
  int marks_seen = 0;
  int results_seen = 0;
  int burst_left = 0;

  rx_mode_t    rx_mode = RX_FREE;
  logic [15:0] rx_tick = 16'd0;

  utf8_validate_newline_normalize_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_last    (out_run_last),
    .out_frame_done  (out_frame_done),
    .out_frame_ok    (out_frame_ok),
    .out_bom_removed (out_bom_removed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("utf8_validate_newline_normalize_core regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[5:0] == 6'd0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_FREE:        out_ready <= 1'b1;
      RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
      RX_ONE_IN_FOUR: out_ready <= (rx_tick[1:0] == 2'd3);
      default:        out_ready <= (rx_tick[3:0] >= 4'd10);
    endcase
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    text_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_text.size() == 0) begin
        $error("unexpected result: out_byte 'h%0h, out_frame_done %0b",
               out_byte, out_frame_done);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_byte_valid", 8'(want.data_valid), 8'(out_byte_valid));
        check_field("out_run_last", 8'(want.run_end), 8'(out_run_last));
        check_field("out_frame_done", 8'(want.done), 8'(out_frame_done));
        check_field("out_frame_ok", 8'(want.ok), 8'(out_frame_ok));
        check_field("out_bom_removed", 8'(want.mark), 8'(out_bom_removed));
      end
    end
  end

  function automatic void clear_frame();
    pend_cont    = 2'd0;
    cr_seen      = 1'b0;
    frame_first  = 1'b1;
    hold_bytes   = 16'h0000;
    hold_cnt     = 2'd0;
    frame_bad    = 1'b0;
    mark_dropped = 1'b0;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  function automatic void normalise_byte(input logic [7:0] b, input logic last);
    logic [7:0]   emit [3];
    int           n;
    logic         start;
    logic         bad_now;
    logic         ok;
    text_result_t r;
    n       = 0;
    start   = frame_first;
    bad_now = 1'b0;
    frame_first = 1'b0;
    live_items++;
    if (!frame_bad) begin
      if (pend_cont == 2'd0) begin
        if (cr_seen && b == CHAR_LF) begin
          cr_seen = 1'b0;
        end else begin
          cr_seen = 1'b0;
          if (b[7] == 1'b0) begin
            if (b == CHAR_CR) begin
              emit[n++] = CHAR_LF;
              cr_seen = 1'b1;
            end else begin
              emit[n++] = b;
            end
          end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            pend_cont = 2'd1;
            emit[n++] = b;
          end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            pend_cont = 2'd2;
            if (start && b == BOM_B0) begin
              hold_bytes = {8'h00, b};
              hold_cnt   = 2'd1;
            end else begin
              emit[n++] = b;
            end
          end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            pend_cont = 2'd3;
            emit[n++] = b;
          end else begin
            bad_now = 1'b1;
          end
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        bad_now = 1'b1;
      end else begin
        pend_cont = pend_cont - 2'd1;
        if (hold_cnt == 2'd1) begin
          if (b == BOM_B1) begin
            hold_bytes[15:8] = b;
            hold_cnt = 2'd2;
          end else begin
            emit[n++] = hold_bytes[7:0];
            emit[n++] = b;
            hold_bytes = 16'h0000;
            hold_cnt   = 2'd0;
          end
        end else if (hold_cnt == 2'd2) begin
          if (b == BOM_B2) begin
            mark_dropped = 1'b1;
          end else begin
            emit[n++] = hold_bytes[7:0];
            emit[n++] = hold_bytes[15:8];
            emit[n++] = b;
          end
          hold_bytes = 16'h0000;
          hold_cnt   = 2'd0;
        end else begin
          emit[n++] = b;
        end
      end
      if (!bad_now && last && pend_cont != 2'd0) begin
        bad_now = 1'b1;
      end
      if (bad_now) begin
        frame_bad = 1'b1;
        n = 0;
      end
    end

    ok = !frame_bad;
    if (last && n == 0) begin
      r = '{data: 8'h00, data_valid: 1'b0, run_end: 1'b1, done: 1'b1,
            ok: ok, mark: ok && mark_dropped};
      expected_text = {expected_text, r};
    end
    for (int k = 0; k < n; k++) begin
      r.data       = emit[k];
      r.data_valid = 1'b1;
      r.run_end    = (k == n - 1);
      r.done       = last && (k == n - 1);
      r.ok         = r.done && ok;
      r.mark       = r.done && ok && mark_dropped;
      expected_text = {expected_text, r};
    end
    if (last) begin
      frames_sent++;
      if (!ok) begin
        frames_bad++;
      end else if (mark_dropped) begin
        marks_seen++;
      end
      clear_frame();
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    normalise_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_item(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return CONT_TAG | 8'($urandom_range(0, 63));
  endfunction

  task automatic add_char();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: queue_byte(CHAR_CR);
      1: queue_byte(CHAR_LF);
      2, 3, 4: queue_byte(8'($urandom_range(0, 127)));
      5, 6: begin
        queue_byte(LEAD2_TAG | 8'($urandom_range(0, 31)));
        queue_byte(cont_byte());
      end
      7, 8: begin
        queue_byte(LEAD3_TAG | 8'($urandom_range(0, 15)));
        repeat (2) queue_byte(cont_byte());
      end
      default: begin
        queue_byte(LEAD4_TAG | 8'($urandom_range(0, 7)));
        repeat (3) queue_byte(cont_byte());
      end
    endcase
  endtask

  task automatic test_line_endings();
    frame_q = '{8'h00, CHAR_CR, CHAR_CR, CHAR_LF, 8'h7F};
    send_frame();
  endtask

  task automatic test_multibyte();
    frame_q = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_frame();
  endtask

  task automatic test_mark();
    frame_q = '{BOM_B0, BOM_B1, BOM_B2, 8'h41};
    send_frame();
    frame_q = '{BOM_B0, BOM_B1, 8'h80};
    send_frame();
    frame_q = '{BOM_B0, 8'h80, 8'h80};
    send_frame();
  endtask

  task automatic test_broken();
    frame_q = '{8'hFF, 8'h41, 8'h00};
    send_frame();
    frame_q = '{8'hC3, 8'h41};
    send_frame();
    frame_q = '{8'hF0, 8'h90};
    send_frame();
  endtask

  task automatic test_random_frames();
    int start_items;
    int kind;
    int pos;
    start_items = live_items;
    while (live_items - start_items < RANDOM_ITEMS) begin
      frame_q.delete();
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        frame_q = '{BOM_B0, BOM_B1, BOM_B2};
      end else if (kind == 1) begin
        queue_byte(BOM_B0);
        if ($urandom_range(0, 1)) queue_byte(BOM_B1);
        else queue_byte(cont_byte());
        queue_byte(cont_byte());
      end
      repeat ($urandom_range(kind <= 1 ? 0 : 1, 6)) add_char();
      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, frame_q.size() - 1);
        case ($urandom_range(0, 2))
          0: frame_q[pos] = 8'($urandom_range(0, 255));
          1: if (frame_q.size() > 1) frame_q.pop_back();
          default: frame_q.insert(pos, cont_byte());
        endcase
      end
      send_frame();
    end
  endtask

  initial begin
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_line_endings();
    test_multibyte();
    test_mark();
    test_broken();
    test_random_frames();
    in_valid <= 1'b0;

    while (expected_text.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d frames (%0d broken, %0d with mark stripped), %0d results",
             frames_sent, frames_bad, marks_seen, results_seen);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("utf8_validate_newline_normalize_core regression: pass");
    end else begin
      $display("utf8_validate_newline_normalize_core regression: fail");
    end
    $finish;
  end

endmodule

// File: utf8_validate_newline_normalize_core.f
src/utf8v_pkg.sv
src/utf8v_step.sv
src/utf8_validate_newline_normalize_core.sv
tb/tb_utf8_validate_newline_normalize_core.sv
